// ===== rtl/acw_pkg.sv =====
// Shared types, field widths and codes for the access card whitelist.
// No dependencies; every other file of the block imports this package.
package acw_pkg;

	// Table size default
	localparam int ACW_CAPACITY = 64;

	// Field widths
	localparam int UID_W     = 32;
	localparam int TIME_W    = 48;
	localparam int RND_W     = 16;
	localparam int WIN_W     = 32;
	localparam int SWP_W     = 8;
	localparam int OUTC_W    = 3;
	localparam int ENT_W     = 7;
	localparam int SLOT_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// Outcome codes
	localparam logic [OUTC_W-1:0] OUT_NONE        = 3'd0;
	localparam logic [OUTC_W-1:0] OUT_MASTER_SET  = 3'd1;
	localparam logic [OUTC_W-1:0] OUT_MASTER_IDLE = 3'd2;
	localparam logic [OUTC_W-1:0] OUT_ENROLLED    = 3'd3;
	localparam logic [OUTC_W-1:0] OUT_REPLACED    = 3'd4;
	localparam logic [OUTC_W-1:0] OUT_CLEARED     = 3'd5;
	localparam logic [OUTC_W-1:0] OUT_DENIED      = 3'd6;
	localparam logic [OUTC_W-1:0] OUT_GRANTED     = 3'd7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENROLL_WIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_WIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_SWIPES = 2'd2;

	// Configuration reset values
	localparam logic [WIN_W-1:0] ENROLL_WIN_RST   = WIN_W'(3 * 1000000);
	localparam logic [WIN_W-1:0] CLEAN_WIN_RST    = WIN_W'(2 * 1000000);
	localparam logic [SWP_W-1:0] CLEAN_SWIPES_RST = SWP_W'(10);

	typedef struct packed {
		logic [WIN_W-1:0] enroll_win;
		logic [WIN_W-1:0] clean_win;
		logic [SWP_W-1:0] clean_swipes;
	} acw_cfg_t;

	typedef struct packed {
		logic [OUTC_W-1:0] outcome;
		logic [ENT_W-1:0]  entries_before;
		logic [ENT_W-1:0]  entries_after;
		logic [SLOT_W-1:0] slot_written;
		logic              expired_seen;
	} acw_result_t;

endpackage

// ===== rtl/acw_table.sv =====
// Card UID table: single write port, single registered read port.
// Depends on acw_pkg for the UID width.
module acw_table #(
	parameter int DEPTH = acw_pkg::ACW_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [acw_pkg::UID_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [acw_pkg::UID_W-1:0] rd_data
);
	import acw_pkg::*;

	logic [UID_W-1:0] mem [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/acw_ctrl.sv =====
// Sequencer for the whitelist: linear table search, one shared add/compare
// for the time windows, reciprocal-multiply slot remainder. Depends on acw_pkg, acw_table.
module acw_ctrl #(
	parameter int CAPACITY = acw_pkg::ACW_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [acw_pkg::UID_W-1:0]   card_uid,
	input  logic [acw_pkg::TIME_W-1:0]  now_us,
	input  logic                        reader_expired,
	input  logic [acw_pkg::RND_W-1:0]   random_word,
	input  acw_pkg::acw_cfg_t           cfg,
	output logic                        busy,
	output logic                        done,
	output acw_pkg::acw_result_t        res
);
	import acw_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// random_word / CAPACITY as (random_word * MOD_MUL) >> MOD_SH, exact for 16-bit words
	localparam int     MOD_SH = RND_W + AW;
	localparam longint MOD_K  = ((longint'(1) << MOD_SH) + longint'(CAPACITY) - 1) /
		longint'(CAPACITY);
	localparam int     MW     = RND_W + 2;
	localparam logic [MW-1:0]    MOD_MUL = MW'(MOD_K);
	localparam logic [RND_W-1:0] CAP_W   = RND_W'(CAPACITY);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_ENR  = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_CLN  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;
	localparam logic [2:0] S_QUO  = 3'd6;

	logic [2:0]        state_q;
	logic [UID_W-1:0]  uid_q;
	logic [TIME_W-1:0] now_q;
	logic [RND_W-1:0]  rnd_q;
	logic              exp_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     before_q;
	logic [UID_W-1:0]  pend_q;
	logic [TIME_W-1:0] ptime_q;
	logic [SWP_W-1:0]  rapid_q;
	logic [TIME_W-1:0] lmt_q;
	logic [OUTC_W-1:0] outc_q;
	logic [AW-1:0]     slot_q;
	logic [AW-1:0]     addr_q;
	logic              iss_q;
	logic              iss_s1;
	logic [AW-1:0]     idx_s1;
	logic [RND_W-1:0]  quo_q;

	logic              accept;
	logic              full;
	logic [CW-1:0]     cnt_m1;
	logic [AW-1:0]     last_addr;
	logic [UID_W-1:0]  rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [UID_W-1:0]  wr_data;
	logic [TIME_W-1:0] cmp_base;
	logic [WIN_W-1:0]  cmp_win;
	logic [TIME_W:0]   cmp_sum;
	logic              lt;
	logic              enroll_ok;
	logic              over_limit;
	logic [RND_W+MW-1:0] mod_prod;
	logic [RND_W-1:0]  quo_nx;
	logic [RND_W-1:0]  mod_rem;
	logic [AW-1:0]     mod_slot;

	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_OUT);
	assign accept    = start && (state_q == S_IDLE);
	assign full      = (count_q == CAP_C);
	assign cnt_m1    = count_q - CW'(1);
	assign last_addr = cnt_m1[AW-1:0];

	// Shared window unit: now < base + window, formed without wrap
	always_comb begin
		if (state_q == S_ENR) begin
			cmp_base = ptime_q;
			cmp_win  = cfg.enroll_win;
		end else begin
			cmp_base = lmt_q;
			cmp_win  = cfg.clean_win;
		end
		cmp_sum = {1'b0, cmp_base} + (TIME_W + 1)'(cmp_win);
		lt      = ({1'b0, now_q} < cmp_sum);
	end

	assign enroll_ok  = lt && (pend_q != '0);
	assign over_limit = (({1'b0, rapid_q} + (SWP_W + 1)'(1)) > {1'b0, cfg.clean_swipes});

	// Slot pick: quotient by reciprocal multiply, registered; remainder in the next cycle
	assign mod_prod = {{MW{1'b0}}, rnd_q} * {{RND_W{1'b0}}, MOD_MUL};
	assign quo_nx   = RND_W'(mod_prod >> MOD_SH);
	assign mod_rem  = rnd_q - quo_q * CAP_W;
	assign mod_slot = mod_rem[AW-1:0];

	// Table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = pend_q;
		if (accept && (card_uid != '0) && (count_q == '0)) begin
			wr_en   = 1'b1;
			wr_data = card_uid;
		end else if ((state_q == S_ENR) && enroll_ok && !full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
		end else if (state_q == S_MOD) begin
			wr_en   = 1'b1;
			wr_addr = mod_slot;
		end
	end

	acw_table #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  ((state_q == S_SCAN) && iss_q),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			pend_q   <= '0;
			ptime_q  <= '0;
			rapid_q  <= '0;
			lmt_q    <= '0;
			iss_q    <= 1'b0;
			iss_s1   <= 1'b0;
			idx_s1   <= '0;
			addr_q   <= '0;
			uid_q    <= '0;
			now_q    <= '0;
			rnd_q    <= '0;
			exp_q    <= 1'b0;
			before_q <= '0;
			outc_q   <= OUT_NONE;
			slot_q   <= '0;
			quo_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						uid_q    <= card_uid;
						now_q    <= now_us;
						rnd_q    <= random_word;
						exp_q    <= reader_expired;
						before_q <= count_q;
						slot_q   <= '0;
						addr_q   <= '0;
						iss_s1   <= 1'b0;
						if (card_uid == '0) begin
							outc_q  <= OUT_NONE;
							state_q <= S_OUT;
						end else if (count_q == '0) begin
							count_q <= CW'(1);
							outc_q  <= OUT_MASTER_SET;
							state_q <= S_OUT;
						end else begin
							iss_q   <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Issue the next read while the previous one is compared
					idx_s1 <= addr_q;
					if (iss_s1 && (rd_data == uid_q)) begin
						iss_q  <= 1'b0;
						iss_s1 <= 1'b0;
						if (idx_s1 == '0) begin
							state_q <= S_ENR;
						end else begin
							outc_q  <= OUT_GRANTED;
							state_q <= S_OUT;
						end
					end else if (iss_s1 && (idx_s1 == last_addr)) begin
						iss_q   <= 1'b0;
						iss_s1  <= 1'b0;
						outc_q  <= OUT_DENIED;
						pend_q  <= uid_q;
						ptime_q <= now_q;
						state_q <= S_OUT;
					end else begin
						iss_s1 <= iss_q;
						if (iss_q) begin
							if (addr_q == last_addr) begin
								iss_q <= 1'b0;
							end else begin
								addr_q <= addr_q + AW'(1);
							end
						end
					end
				end
				S_ENR: begin
					if (enroll_ok) begin
						if (full) begin
							state_q <= S_QUO;
						end else begin
							slot_q  <= count_q[AW-1:0];
							count_q <= count_q + CW'(1);
							outc_q  <= OUT_ENROLLED;
							pend_q  <= '0;
							ptime_q <= '0;
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_CLN;
					end
				end
				S_QUO: begin
					// Hold the quotient of the random word
					quo_q   <= quo_nx;
					state_q <= S_MOD;
				end
				S_MOD: begin
					// Overwrite the picked slot with the pending card
					slot_q  <= mod_slot;
					outc_q  <= OUT_REPLACED;
					pend_q  <= '0;
					ptime_q <= '0;
					state_q <= S_OUT;
				end
				S_CLN: begin
					// Count rapid master swipes, clear the table past the limit
					lmt_q <= now_q;
					if (lt && over_limit) begin
						count_q <= '0;
						rapid_q <= '0;
						outc_q  <= OUT_CLEARED;
					end else if (lt) begin
						rapid_q <= rapid_q + SWP_W'(1);
						outc_q  <= OUT_MASTER_IDLE;
					end else begin
						rapid_q <= '0;
						outc_q  <= OUT_MASTER_IDLE;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result beat
	always_comb begin
		res.outcome        = outc_q;
		res.entries_before = ENT_W'(before_q);
		res.entries_after  = ENT_W'(count_q);
		res.slot_written   = SLOT_W'(slot_q);
		res.expired_seen   = exp_q;
	end

endmodule

// ===== rtl/access_card_whitelist.sv =====
// Access card whitelist top level: configuration registers and result ports.
// Depends on acw_pkg and acw_ctrl (which holds the card table).
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  item      start / busy         card_uid, now_us, reader_expired, random_word
//  result    done (1-cycle)       outcome, entries_before, entries_after,
//                                 slot_written, expired_seen
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Steps per item: no card, or a card into an empty table, is answered without
// a table search. Otherwise the table is searched one entry per cycle and the
// search stops at the first match or after the last entry. A master swipe then
// enrols the pending card, counts towards a clear, or overwrites a slot of a
// full table.
// Reset clears all control state; table contents stay undefined until written.
// The receiver cannot stall: done is high for one cycle with the result beat.
module access_card_whitelist #(
	parameter int CAPACITY = acw_pkg::ACW_CAPACITY
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [acw_pkg::UID_W-1:0]      card_uid,
	input  logic [acw_pkg::TIME_W-1:0]     now_us,
	input  logic                           reader_expired,
	input  logic [acw_pkg::RND_W-1:0]      random_word,
	output logic                           done,
	output logic [acw_pkg::OUTC_W-1:0]     outcome,
	output logic [acw_pkg::ENT_W-1:0]      entries_before,
	output logic [acw_pkg::ENT_W-1:0]      entries_after,
	output logic [acw_pkg::SLOT_W-1:0]     slot_written,
	output logic                           expired_seen,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [acw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acw_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import acw_pkg::*;

	acw_cfg_t    cfg_q;
	acw_result_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes drop the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enroll_win   <= ENROLL_WIN_RST;
			cfg_q.clean_win    <= CLEAN_WIN_RST;
			cfg_q.clean_swipes <= CLEAN_SWIPES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENROLL_WIN:   cfg_q.enroll_win   <= cfg_data[WIN_W-1:0];
				CFG_CLEAN_WIN:    cfg_q.clean_win    <= cfg_data[WIN_W-1:0];
				CFG_CLEAN_SWIPES: cfg_q.clean_swipes <= cfg_data[SWP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	acw_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.card_uid      (card_uid),
		.now_us        (now_us),
		.reader_expired(reader_expired),
		.random_word   (random_word),
		.cfg           (cfg_q),
		.busy          (busy),
		.done          (done),
		.res           (res)
	);

	// Split the result beat onto its ports
	assign outcome        = res.outcome;
	assign entries_before = res.entries_before;
	assign entries_after  = res.entries_after;
	assign slot_written   = res.slot_written;
	assign expired_seen   = res.expired_seen;

endmodule

// ===== rtl/acw_checker.sv =====
// Port-level checks for the access card whitelist, bound to the top level.
// Depends on acw_pkg and access_card_whitelist.
module acw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [acw_pkg::OUTC_W-1:0]    outcome,
	input logic [acw_pkg::ENT_W-1:0]     entries_before,
	input logic [acw_pkg::ENT_W-1:0]     entries_after,
	input logic [acw_pkg::SLOT_W-1:0]    slot_written
);
	import acw_pkg::*;

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// A result beat lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// Results appear only while an item is in progress
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat without an item in progress");

	// No card leaves the count untouched
	a_none_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (outcome == OUT_NONE) |-> (entries_before == entries_after))
		else $error("count changed with no card");

	// Only writes report a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((outcome == OUT_DENIED) || (outcome == OUT_GRANTED) ||
		(outcome == OUT_MASTER_IDLE) || (outcome == OUT_CLEARED)) |-> (slot_written == '0))
		else $error("slot reported without a table write");

endmodule

bind access_card_whitelist acw_checker u_acw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.outcome       (outcome),
	.entries_before(entries_before),
	.entries_after (entries_after),
	.slot_written  (slot_written)
);
